@@ sv/palette_error_diffusion_dither_defines.svh @@
// Assertion macros for the palette error diffusion dither block.
`ifndef PALETTE_ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define PALETTE_ERROR_DIFFUSION_DITHER_DEFINES_SVH

// prop must hold at every clock edge out of reset
`define PED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// cond must never be true out of reset
`define PED_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ sv/ped_pkg.sv @@
// Types, register map and fixed-point helpers of the palette dither block.
`timescale 1ns / 1ps
package ped_pkg;

  localparam int QW = 14;
  localparam int EW = 16;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [EW-1:0] e_t;
  typedef logic [2:0][QW-1:0]   err_t;
  typedef logic [2:0][EW-1:0]   share_t;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_TILE_SIZE     = 2'd1;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd2;

  localparam logic [3:0] K_RIGHT      = 4'd7;
  localparam logic [3:0] K_BELOW_LEFT = 4'd3;
  localparam logic [3:0] K_BELOW      = 4'd5;
  localparam logic [3:0] K_BELOW_RIGHT = 4'd1;

  localparam logic signed [16:0] SAT_MIN = -17'sd8192;
  localparam logic signed [16:0] SAT_MAX = 17'sd8191;

  function automatic q_t sat_q(input logic signed [16:0] v);
    q_t r;
    if (v < SAT_MIN) r = q_t'(SAT_MIN);
    else if (v > SAT_MAX) r = q_t'(SAT_MAX);
    else r = q_t'(v);
    return r;
  endfunction

  function automatic q_t add_sat(input q_t a, input e_t b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    return sat_q(s);
  endfunction

  // (e * k) / 16, truncating toward zero
  function automatic e_t share_of(input e_t e, input logic [3:0] k);
    logic signed [20:0] p;
    p = 21'(e) * $signed({1'b0, k});
    if (p < 0) p = p + 21'sd15;
    return e_t'(p >>> 4);
  endfunction

endpackage

@@ sv/ped_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module ped_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/palette_error_diffusion_dither.sv @@
// Top level: nearest palette colour search with error diffusion to neighbors.
//
//  channel   dir  beat fields
//  s_axis    in   tuser: req_type; tdata: entry_index, red, green, blue, skip
//  m_axis    out  tdata: index, red, green, blue, place_x, place_y, place_tile
//  apb       in   image_width @0x0, tile_size @0x4, palette_count @0x8
//
// A palette load is written as its beat is taken; the block stays ready. A pixel
// result is loaded after the sum, scan, error and two write-back states, and the
// next beat is taken once it is loaded; a pixel's time is set by the palette scan
// through one RAM read port. After reset the error line RAM is zeroed, one entry
// a cycle, with s_axis_tready low. A new beat is accepted while a result waits; a
// pixel stalls only in its output state while m_axis holds an untaken result.
`timescale 1ns / 1ps
`include "palette_error_diffusion_dither_defines.svh"
module palette_error_diffusion_dither import ped_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int PALETTE_SIZE = 64,
  parameter int MAX_HEIGHT   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_index[5:0] red[13:6] green[21:14] blue[29:22] skip[30]
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // index[5:0] red[13:6] green[21:14] blue[29:22]
                                     // place_x[48:30] place_y[68:49] place_tile[69]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(PALETTE_SIZE);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_ERR   = 8'b0001_0000,
    S_WR1   = 8'b0010_0000,
    S_WR2   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [11:0] width_q;
  logic [8:0]  tile_q;
  logic [6:0]  pcnt_q;
  logic        cfg_wr;

  logic [XW:0] w_eff;
  logic [PW:0] n_eff;

  logic [XW-1:0]   clr_q, clr_d;
  logic [XW:0]     col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [XW-1:0]   x_q, x_d;
  logic [2:0][7:0] pix_q, pix_d;
  err_t            v_q, v_d, right_q, right_d, below_q, below_d, prev_q, prev_d;

  logic [PW:0]     scan_q, scan_d;
  logic            p1_vld_q, p1_vld_d, p2_vld_q, p2_vld_d;
  logic [PW-1:0]   idx1_q, idx1_d, idx2_q, idx2_d;
  logic [2:0][29:0] sq_q, sq_d;
  logic [24:0]     pal2_q, pal2_d;
  logic            best_vld_q, best_vld_d;
  logic [31:0]     best_d_q, best_d_d;
  logic [PW-1:0]   best_idx_q, best_idx_d;
  logic [24:0]     best_pal_q, best_pal_d;
  share_t          sh1_q, sh3_q, sh5_q, sh7_q, sh1_d, sh3_d, sh5_d, sh7_d;

  logic        out_vld_q, out_vld_d;
  logic [71:0] out_q, out_d;

  logic          pal_we;
  logic [24:0]   pal_rdata;
  logic          err_we;
  logic [XW-1:0] err_waddr, err_raddr;
  err_t          err_wdata, err_rdata;

  logic          acc;
  logic          in_pixel;
  logic [5:0]    in_idx;
  logic          idx_ok;
  logic [XW:0]   x_acc;
  logic          pre_wrap;
  logic          out_load;
  logic [31:0]   dist_sum;
  logic [RW-1:0] row_next;
  logic [XW:0]   col_next;
  logic [XW+8:0] px_full;
  logic [RW+8:0] py_full;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd64;
      tile_q  <= 9'd16;
      pcnt_q  <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IMAGE_WIDTH:   width_q <= pwdata[11:0];
        REG_TILE_SIZE:     tile_q  <= pwdata[8:0];
        REG_PALETTE_COUNT: pcnt_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_WIDTH:   prdata = {20'd0, width_q};
      REG_TILE_SIZE:     prdata = {23'd0, tile_q};
      REG_PALETTE_COUNT: prdata = {25'd0, pcnt_q};
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (width_q == 12'd0) w_eff = (XW+1)'(1);
    else if ({20'd0, width_q} > 32'(MAX_WIDTH)) w_eff = (XW+1)'(MAX_WIDTH);
    else w_eff = (XW+1)'(width_q);
    if (pcnt_q == 7'd0) n_eff = (PW+1)'(1);
    else if ({25'd0, pcnt_q} > 32'(PALETTE_SIZE)) n_eff = (PW+1)'(PALETTE_SIZE);
    else n_eff = (PW+1)'(pcnt_q);
  end

  // input side
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc      = s_axis_tvalid & s_axis_tready;
  assign in_pixel = s_axis_tuser;
  assign in_idx   = s_axis_tdata[5:0];
  assign idx_ok   = ({26'd0, in_idx} < 32'(PALETTE_SIZE));
  assign pal_we   = acc & !in_pixel & idx_ok;
  assign pre_wrap = (col_q >= w_eff);
  assign x_acc    = pre_wrap ? '0 : col_q;
  assign row_next = (row_q == RW'(MAX_HEIGHT - 1)) ? '0 : row_q + 1'b1;

  ped_ram #(.WIDTH(25), .DEPTH(PALETTE_SIZE)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (PW'(in_idx)),
    .wdata_i ({s_axis_tdata[30], s_axis_tdata[29:6]}),
    .raddr_i (scan_q[PW-1:0]),
    .rdata_o (pal_rdata)
  );

  ped_ram #(.WIDTH(3 * QW), .DEPTH(MAX_WIDTH)) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (err_we),
    .waddr_i (err_waddr),
    .wdata_i (err_wdata),
    .raddr_i (err_raddr),
    .rdata_o (err_rdata)
  );

  assign err_raddr = x_acc[XW-1:0];

  always_comb begin
    err_we    = 1'b0;
    err_waddr = x_q;
    err_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        err_we    = 1'b1;
        err_waddr = clr_q;
      end
      S_WR1: begin
        err_we    = (x_q != '0);
        err_waddr = x_q - 1'b1;
        for (int c = 0; c < 3; c++) begin
          err_wdata[c] = add_sat(prev_q[c], sh3_q[c]);
        end
      end
      S_WR2: begin
        err_we = 1'b1;
        for (int c = 0; c < 3; c++) begin
          err_wdata[c] = add_sat(below_q[c], sh5_q[c]);
        end
      end
      default: ;
    endcase
  end

  assign dist_sum = 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
  assign out_load = (state_q == S_OUT) && (!out_vld_q || m_axis_tready);
  assign col_next = {1'b0, x_q} + 1'b1;
  assign px_full  = (XW+9)'(x_q) * (XW+9)'(tile_q);
  assign py_full  = (RW+9)'(row_q) * (RW+9)'(tile_q);

  always_comb begin
    e_t diff;
    e_t e;
    logic signed [31:0] sq;
    diff       = '0;
    e          = '0;
    sq         = '0;
    state_d    = state_q;
    clr_d      = clr_q;
    col_d      = col_q;
    row_d      = row_q;
    x_d        = x_q;
    pix_d      = pix_q;
    v_d        = v_q;
    right_d    = right_q;
    below_d    = below_q;
    prev_d     = prev_q;
    scan_d     = scan_q;
    p1_vld_d   = 1'b0;
    idx1_d     = idx1_q;
    p2_vld_d   = 1'b0;
    idx2_d     = idx2_q;
    sq_d       = sq_q;
    pal2_d     = pal2_q;
    best_vld_d = best_vld_q;
    best_d_d   = best_d_q;
    best_idx_d = best_idx_q;
    best_pal_d = best_pal_q;
    sh1_d      = sh1_q;
    sh3_d      = sh3_q;
    sh5_d      = sh5_q;
    sh7_d      = sh7_q;
    out_vld_d  = out_vld_q & !m_axis_tready;
    out_d      = out_q;

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == XW'(MAX_WIDTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc && in_pixel) begin
          x_d   = x_acc[XW-1:0];
          pix_d = s_axis_tdata[29:6];
          if (pre_wrap) begin
            row_d   = row_next;
            right_d = '0;
            below_d = '0;
          end
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        for (int c = 0; c < 3; c++) begin
          v_d[c] = sat_q(17'($signed({1'b0, pix_q[c], 4'b0})) + 17'(q_t'(err_rdata[c]))
                         + 17'(q_t'(right_q[c])));
        end
        scan_d     = '0;
        best_vld_d = 1'b0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (scan_q < n_eff) begin
          p1_vld_d = 1'b1;
          idx1_d   = scan_q[PW-1:0];
          scan_d   = scan_q + 1'b1;
        end
        p2_vld_d = p1_vld_q;
        if (p1_vld_q) begin
          idx2_d = idx1_q;
          pal2_d = pal_rdata;
          for (int c = 0; c < 3; c++) begin
            diff    = e_t'(q_t'(v_q[c])) - e_t'({4'b0, pal_rdata[c*8 +: 8], 4'b0});
            sq      = diff * diff;
            sq_d[c] = sq[29:0];
          end
        end
        if (p2_vld_q && (!best_vld_q || dist_sum < best_d_q)) begin
          best_vld_d = 1'b1;
          best_d_d   = dist_sum;
          best_idx_d = idx2_q;
          best_pal_d = pal2_q;
        end
        if (scan_q == n_eff && !p1_vld_q && !p2_vld_q) state_d = S_ERR;
      end
      S_ERR: begin
        for (int c = 0; c < 3; c++) begin
          e        = e_t'(q_t'(v_q[c])) - e_t'({4'b0, best_pal_q[c*8 +: 8], 4'b0});
          sh1_d[c] = share_of(e, K_BELOW_RIGHT);
          sh3_d[c] = share_of(e, K_BELOW_LEFT);
          sh5_d[c] = share_of(e, K_BELOW);
          sh7_d[c] = share_of(e, K_RIGHT);
        end
        state_d = S_WR1;
      end
      S_WR1: begin
        state_d = S_WR2;
      end
      S_WR2: begin
        prev_d = err_wdata;
        for (int c = 0; c < 3; c++) begin
          below_d[c] = add_sat('0, sh1_q[c]);
          right_d[c] = add_sat('0, sh7_q[c]);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          out_d = {2'b0, !best_pal_q[24], 20'(py_full), 19'(px_full),
                   best_pal_q[23:0], 6'(best_idx_q)};
          if (col_next >= w_eff) begin
            col_d   = '0;
            row_d   = row_next;
            right_d = '0;
            below_d = '0;
          end else begin
            col_d = col_next;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      right_q    <= '0;
      below_q    <= '0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      scan_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      col_q      <= col_d;
      row_q      <= row_d;
      right_q    <= right_d;
      below_q    <= below_d;
      p1_vld_q   <= p1_vld_d;
      p2_vld_q   <= p2_vld_d;
      best_vld_q <= best_vld_d;
      scan_q     <= scan_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    pix_q      <= pix_d;
    v_q        <= v_d;
    prev_q     <= prev_d;
    idx1_q     <= idx1_d;
    idx2_q     <= idx2_d;
    sq_q       <= sq_d;
    pal2_q     <= pal2_d;
    best_d_q   <= best_d_d;
    best_idx_q <= best_idx_d;
    best_pal_q <= best_pal_d;
    sh1_q      <= sh1_d;
    sh3_q      <= sh3_d;
    sh5_q      <= sh5_d;
    sh7_q      <= sh7_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `PED_ASSERT(a_best_in_range, (state_q == S_ERR) |-> ({1'b0, best_idx_q} < n_eff), "best index beyond palette count")
  `PED_ASSERT(a_best_found, (state_q == S_ERR) |-> best_vld_q, "scan ended without a candidate")
  `PED_ASSERT(a_col_in_row, out_load |=> (col_q < $past(w_eff)), "column left past row width")
  `PED_ASSERT_NEVER(a_pipe_outside_scan, (p2_vld_q && state_q != S_SCAN), "scan pipe active outside scan")

endmodule

@@ verif/tb_palette_error_diffusion_dither.sv @@
// Self-checking testbench of the palette error diffusion dither block.
`timescale 1ns / 1ps
module tb_palette_error_diffusion_dither import ped_pkg::*; ();

  localparam int MAXW = 2048;
  localparam int PSIZE = 64;
  localparam int MAXH = 4096;
  localparam int QMIN = -8192;
  localparam int QMAX = 8191;

  typedef struct packed {
    logic       kind;
    logic [5:0] slot;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       skip;
  } beat_in_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [18:0] px;
    logic [19:0] py;
    logic        tile;
  } pixel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  palette_error_diffusion_dither dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  int unsigned width_reg = 64, tile_reg = 16, count_reg = 64;
  logic [7:0] pal_rgb [PSIZE][3];
  logic pal_skip [PSIZE];
  int line_err [MAXW][3];
  int right_err [3];
  int below_err [3];
  int unsigned col_cnt, row_cnt;

  beat_in_t pending_beats[$];
  pixel_out_t expected_pixels[$];
  int errors = 0;
  int send_idle = 29, recv_idle = 57;
  bit hold_send = 1'b0;
  logic s_axis_tready_q = 1'b0;

  function automatic int sat14(int v);
    return v < QMIN ? QMIN : (v > QMAX ? QMAX : v);
  endfunction

  function automatic int share(int e, int k);
    return (e * k) / 16;
  endfunction

  function automatic void next_row();
    col_cnt = 0;
    row_cnt = (row_cnt + 1 >= MAXH) ? 0 : row_cnt + 1;
    for (int c = 0; c < 3; c++) begin
      right_err[c] = 0;
      below_err[c] = 0;
    end
  endfunction

  function automatic void predict_dither(beat_in_t it);
    int unsigned w, n, x, best;
    int v[3], e[3];
    longint bd, d, df;
    pixel_out_t o;
    logic [7:0] pin[3];
    if (!it.kind) begin
      pal_rgb[it.slot][0] = it.r;
      pal_rgb[it.slot][1] = it.g;
      pal_rgb[it.slot][2] = it.b;
      pal_skip[it.slot] = it.skip;
      return;
    end
    pin[0] = it.r; pin[1] = it.g; pin[2] = it.b;
    w = width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
    n = count_reg < 1 ? 1 : (count_reg > PSIZE ? PSIZE : count_reg);
    if (col_cnt >= w) next_row();
    x = col_cnt;
    for (int c = 0; c < 3; c++) v[c] = sat14(int'(pin[c]) * 16 + line_err[x][c] + right_err[c]);
    best = 0;
    bd = -1;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        df = longint'(v[c]) - longint'(pal_rgb[i][c]) * 16;
        d += df * df;
      end
      if (bd < 0 || d < bd) begin
        bd = d;
        best = i;
      end
    end
    for (int c = 0; c < 3; c++) begin
      e[c] = v[c] - int'(pal_rgb[best][c]) * 16;
      if (x > 0) line_err[x-1][c] = sat14(line_err[x-1][c] + share(e[c], 3));
      line_err[x][c] = sat14(below_err[c] + share(e[c], 5));
      below_err[c] = sat14(share(e[c], 1));
      right_err[c] = sat14(share(e[c], 7));
    end
    o.idx = best[5:0];
    o.r = pal_rgb[best][0];
    o.g = pal_rgb[best][1];
    o.b = pal_rgb[best][2];
    o.px = 19'(longint'(x) * tile_reg);
    o.py = 20'(longint'(row_cnt) * tile_reg);
    o.tile = ~pal_skip[best];
    expected_pixels.insert(expected_pixels.size(), o);
    col_cnt = x + 1;
    if (col_cnt >= w) next_row();
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready_q)) begin
      if (pending_beats.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_beats[0].kind;
        s_axis_tdata <= {1'b0, pending_beats[0].skip, pending_beats[0].b, pending_beats[0].g,
                         pending_beats[0].r, pending_beats[0].slot};
        void'(pending_beats.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor: input acceptance feeds predictor, output beats are checked
  always @(posedge clk_i) begin
    beat_in_t ib;
    pixel_out_t got, want;
    s_axis_tready_q <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        ib.kind = s_axis_tuser;
        ib.slot = s_axis_tdata[5:0];
        ib.r = s_axis_tdata[13:6];
        ib.g = s_axis_tdata[21:14];
        ib.b = s_axis_tdata[29:22];
        ib.skip = s_axis_tdata[30];
        predict_dither(ib);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tdata[21:14],
               m_axis_tdata[29:22], m_axis_tdata[48:30], m_axis_tdata[68:49],
               m_axis_tdata[69]};
        if (expected_pixels.size() == 0) begin
          $display("%0t unexpected pixel beat: actual %h", $realtime, got);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            $display("%0t mismatch idx/r/g/b/x/y/tile: expected %0d %0d %0d %0d %0d %0d %0d",
                     $realtime, want.idx, want.r, want.g, want.b, want.px, want.py, want.tile);
            $display("%0t   actual %0d %0d %0d %0d %0d %0d %0d", $realtime, got.idx, got.r,
                     got.g, got.b, got.px, got.py, got.tile);
            errors++;
          end
        end
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH: width_reg = val & 32'hFFF;
      REG_TILE_SIZE: tile_reg = val & 32'h1FF;
      default: count_reg = val & 32'h7F;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic queue_load(int slot, int r, int g, int b, bit skip);
    beat_in_t bt;
    bt = {1'b0, 6'(slot), 8'(r), 8'(g), 8'(b), skip};
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  task automatic queue_pixel(int r, int g, int b);
    beat_in_t bt;
    bt = {1'b1, 6'($urandom), 8'(r), 8'(g), 8'(b), 1'($urandom)};
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  task automatic random_phase(int items, int maxcnt);
    int k;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(19);
      if (k == 0) queue_load($urandom_range(maxcnt - 1), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255),
                             1'($urandom_range(1)));
      else if (k == 1) queue_pixel(255 * $urandom_range(1), 255 * $urandom_range(1),
                                   255 * $urandom_range(1));
      else queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    end
  endtask

  initial begin
    for (int i = 0; i < MAXW; i++) for (int c = 0; c < 3; c++) line_err[i][c] = 0;
    for (int c = 0; c < 3; c++) begin
      right_err[c] = 0;
      below_err[c] = 0;
    end
    col_cnt = 0;
    row_cnt = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: whole palette with ties, then extremes at width 3
    queue_load(0, 0, 0, 0, 1'b0);
    queue_load(1, 255, 255, 255, 1'b1);
    queue_load(2, 0, 0, 0, 1'b1);
    for (int i = 3; i < PSIZE; i++) queue_load(i, i * 4, 255 - i * 4, (i * 37) & 255, i[0]);
    drain();
    apb_write(REG_IMAGE_WIDTH, 3);
    apb_write(REG_TILE_SIZE, 256);
    apb_write(REG_PALETTE_COUNT, 3);
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(255, 0, 255);
    queue_pixel(0, 255, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 255, 255);
    queue_pixel(0, 0, 0);
    hold_send = 1'b1;
    repeat (5) @(posedge clk_i);
    hold_send = 1'b0;
    drain();
    // hold a queued pixel back after everything is out, then release it
    hold_send = 1'b1;
    queue_pixel(10, 20, 30);
    repeat (50) @(posedge clk_i);
    hold_send = 1'b0;
    drain();

    apb_write(REG_IMAGE_WIDTH, 1);
    apb_write(REG_TILE_SIZE, 1);
    apb_write(REG_PALETTE_COUNT, 64);
    random_phase(250, 64);
    drain();

    send_idle = 57; recv_idle = 29;
    apb_write(REG_IMAGE_WIDTH, 7);
    apb_write(REG_TILE_SIZE, $urandom_range(1, 256));
    apb_write(REG_PALETTE_COUNT, 1);
    random_phase(100, 1);
    drain();
    apb_write(REG_PALETTE_COUNT, 0);
    random_phase(50, 1);
    drain();

    send_idle = 0; recv_idle = 0;
    apb_write(REG_IMAGE_WIDTH, 2048);
    apb_write(REG_TILE_SIZE, 255);
    apb_write(REG_PALETTE_COUNT, 16);
    random_phase(150, 16);
    drain();
    apb_write(REG_IMAGE_WIDTH, 0);
    apb_write(REG_PALETTE_COUNT, 127);
    random_phase(125, 64);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
